@@ rtl/core/rtdq_pkg.sv @@
`default_nettype none
package rtdq_pkg;

    // Descriptor of one queued packet.
    typedef struct packed {
        logic [63:0] release_time;
        logic [63:0] seq;
        logic [31:0] profile_version;
        logic [7:0]  direction;
        logic [15:0] handle;
        logic [15:0] length;
    } pkt_t;

    // What a queue cell shows its neighbours.
    typedef struct packed {
        logic valid;
        logic le;
        pkt_t pkt;
    } qlink_t;

    // What a result buffer cell shows its neighbours.
    typedef struct packed {
        logic valid;
        pkt_t pkt;
    } rlink_t;

    // Queue cell operations.
    localparam logic [1:0] Q_HOLD   = 2'd0;
    localparam logic [1:0] Q_SHIFT  = 2'd1;
    localparam logic [1:0] Q_INSERT = 2'd2;
    localparam logic [1:0] Q_CLEAR  = 2'd3;

    // Result buffer cell operations.
    localparam logic [1:0] R_HOLD = 2'd0;
    localparam logic [1:0] R_PUSH = 2'd1;
    localparam logic [1:0] R_POP  = 2'd2;

    // Input modes.
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Result kinds.
    localparam logic [2:0] K_PUSH    = 3'd0;
    localparam logic [2:0] K_EVICT   = 3'd1;
    localparam logic [2:0] K_RELEASE = 3'd2;
    localparam logic [2:0] K_NONE    = 3'd3;
    localparam logic [2:0] K_CLEAR   = 3'd4;

    localparam logic [20:0] BUDGET_RESET = 21'd262144;

endpackage
`default_nettype wire

@@ rtl/core/release_time_delay_queue.sv @@
`default_nettype none
// Delay queue for packet descriptors, earliest release time first, equal times
// in arrival order. Entries sit in a sorted row of DEPTH cells, head in the first
// cell; a push is placed by comparing against every cell at once, and each
// eviction or release moves the row one cell towards the head. A transaction is
// accepted, then takes one step per evicted entry plus a final step, and then
// gives one result per cycle on the output when the output is not stalled; a push
// evicts at most DEPTH entries. Evicted descriptors wait in a second row of cells
// until the transaction is finished, because every result carries the queue
// status after the whole step. A new transaction is taken while the final result
// still waits on the output.
module release_time_delay_queue
    import rtdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [20:0]  cfg_wdata,     // byte budget
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // time_stamp[63:0], payload_handle[79:64], payload_length[95:80],
    // packet_seq[159:96], profile_version[191:160], direction_tag[199:192]
    input  wire logic [199:0] s_tdata,
    input  wire logic [1:0]   s_tuser,       // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // accepted[0], pkt_release_time[64:1], pkt_seq[128:65],
    // pkt_profile_version[160:129], pkt_direction[168:161], pkt_handle[184:169],
    // pkt_length[200:185], queue_nonempty[201], next_release_time[265:202],
    // queued_bytes[286:266], zero[287]
    output logic [287:0]      m_tdata,
    output logic [2:0]        m_tuser,       // kind
    output logic              m_tlast        // last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [20:0] budget_reg;
    logic [20:0] bytes_reg;
    logic [20:0] bytes_next;
    logic [1:0]  mode_reg;
    pkt_t        in_pkt_reg;

    logic [2:0]  fin_kind_reg;
    logic [2:0]  fin_kind_next;
    logic        fin_acc_reg;
    logic        fin_acc_next;
    pkt_t        fin_pkt_reg;
    pkt_t        fin_pkt_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  out_kind_reg;
    logic [2:0]  out_kind_next;
    logic        out_acc_reg;
    logic        out_acc_next;
    pkt_t        out_pkt_reg;
    pkt_t        out_pkt_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic        out_ne_reg;
    logic        out_ne_next;
    logic [63:0] out_next_time_reg;
    logic [63:0] out_next_time_next;
    logic [20:0] out_bytes_reg;
    logic [20:0] out_bytes_next;

    logic [1:0]  q_op;
    logic [1:0]  r_op;
    qlink_t      q_link [DEPTH];
    rlink_t      r_link [DEPTH];

    logic        in_accept;
    logic        over_budget;
    logic        too_big;
    logic [20:0] head_len;
    logic [20:0] bytes_less_head;
    logic        out_load;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    // Queue row: sorted, valid entries packed from the head.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_q
        qlink_t left_l;
        qlink_t right_l;
        if (i == 0)
        begin : g_first
            assign left_l = '{valid: 1'b1, le: 1'b1, pkt: '0};
        end
        else
        begin : g_mid
            assign left_l = q_link[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_l = '0;
        end
        else
        begin : g_inner
            assign right_l = q_link[i+1];
        end
        rtdq_qcell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .op      (q_op),
            .new_pkt (in_pkt_reg),
            .left    (left_l),
            .right   (right_l),
            .self    (q_link[i])
        );
    end

    // Result buffer row: evicted descriptors in the order they left the queue.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_r
        rlink_t left_l;
        rlink_t right_l;
        if (i == 0)
        begin : g_first
            assign left_l = '{valid: 1'b1, pkt: '0};
        end
        else
        begin : g_mid
            assign left_l = r_link[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_l = '0;
        end
        else
        begin : g_inner
            assign right_l = r_link[i+1];
        end
        rtdq_rcell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .op      (r_op),
            .new_pkt (q_link[0].pkt),
            .left    (left_l),
            .right   (right_l),
            .self    (r_link[i])
        );
    end

    // Budget checks against the packet being pushed.
    assign over_budget = ({1'b0, bytes_reg} + {6'd0, in_pkt_reg.length})
                         > {1'b0, budget_reg};
    assign too_big     = {5'd0, in_pkt_reg.length} > budget_reg;
    assign head_len    = {5'd0, q_link[0].pkt.length};
    assign bytes_less_head = (bytes_reg >= head_len) ? (bytes_reg - head_len) : 21'd0;
    assign out_load    = !out_valid_reg || m_tready;

    // Sequencer for one transaction.
    always_comb
    begin
        state_next     = state_reg;
        bytes_next     = bytes_reg;
        fin_kind_next  = fin_kind_reg;
        fin_acc_next   = fin_acc_reg;
        fin_pkt_next   = fin_pkt_reg;
        q_op           = Q_HOLD;
        r_op           = R_HOLD;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_acc_next   = out_acc_reg;
        out_pkt_next   = out_pkt_reg;
        out_last_next  = out_last_reg;
        out_ne_next    = out_ne_reg;
        out_next_time_next = out_next_time_reg;
        out_bytes_next = out_bytes_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                fin_acc_next = 1'b0;
                fin_pkt_next = '0;
                state_next   = ST_EMIT;
                case (mode_reg)
                    MODE_PUSH:
                    begin
                        if ((q_link[0].valid && over_budget) || (!too_big &&
                            q_link[DEPTH-1].valid))
                        begin
                            q_op       = Q_SHIFT;
                            r_op       = R_PUSH;
                            bytes_next = bytes_less_head;
                            state_next = ST_EXEC;
                        end
                        else if (too_big)
                        begin
                            fin_kind_next = K_PUSH;
                        end
                        else
                        begin
                            q_op          = Q_INSERT;
                            bytes_next    = bytes_reg + {5'd0, in_pkt_reg.length};
                            fin_kind_next = K_PUSH;
                            fin_acc_next  = 1'b1;
                        end
                    end
                    MODE_POP:
                    begin
                        if (q_link[0].valid && (q_link[0].pkt.release_time <=
                            in_pkt_reg.release_time))
                        begin
                            q_op          = Q_SHIFT;
                            bytes_next    = bytes_less_head;
                            fin_kind_next = K_RELEASE;
                            fin_pkt_next  = q_link[0].pkt;
                        end
                        else
                        begin
                            fin_kind_next = K_NONE;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        q_op          = Q_CLEAR;
                        bytes_next    = 21'd0;
                        fin_kind_next = K_CLEAR;
                    end
                    default:
                    begin
                        fin_kind_next = K_NONE;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next     = 1'b1;
                    out_ne_next        = q_link[0].valid;
                    out_next_time_next = q_link[0].valid ? q_link[0].pkt.release_time
                                                         : 64'd0;
                    out_bytes_next     = bytes_reg;
                    if (r_link[0].valid)
                    begin
                        r_op          = R_POP;
                        out_kind_next = K_EVICT;
                        out_acc_next  = 1'b0;
                        out_pkt_next  = r_link[0].pkt;
                        out_last_next = 1'b0;
                    end
                    else
                    begin
                        out_kind_next = fin_kind_reg;
                        out_acc_next  = fin_acc_reg;
                        out_pkt_next  = fin_pkt_reg;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bytes_reg     <= 21'd0;
            budget_reg    <= BUDGET_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                budget_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg                   <= s_tuser;
            in_pkt_reg.release_time    <= s_tdata[63:0];
            in_pkt_reg.handle          <= s_tdata[79:64];
            in_pkt_reg.length          <= s_tdata[95:80];
            in_pkt_reg.seq             <= s_tdata[159:96];
            in_pkt_reg.profile_version <= s_tdata[191:160];
            in_pkt_reg.direction       <= s_tdata[199:192];
        end
        fin_kind_reg      <= fin_kind_next;
        fin_acc_reg       <= fin_acc_next;
        fin_pkt_reg       <= fin_pkt_next;
        out_kind_reg      <= out_kind_next;
        out_acc_reg       <= out_acc_next;
        out_pkt_reg       <= out_pkt_next;
        out_last_reg      <= out_last_next;
        out_ne_reg        <= out_ne_next;
        out_next_time_reg <= out_next_time_next;
        out_bytes_reg     <= out_bytes_next;
    end

    // Output transaction.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_bytes_reg, out_next_time_reg, out_ne_reg,
                       out_pkt_reg.length, out_pkt_reg.handle, out_pkt_reg.direction,
                       out_pkt_reg.profile_version, out_pkt_reg.seq,
                       out_pkt_reg.release_time, out_acc_reg};

    // The result buffer is drained before a new transaction is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !r_link[0].valid)
        else $error("result buffer not empty while idle");

    // An empty queue holds no bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        !q_link[0].valid |-> (bytes_reg == 21'd0))
        else $error("byte total non-zero on empty queue");

    // A packet is only placed when the last cell is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_op == Q_INSERT) |-> !q_link[DEPTH-1].valid)
        else $error("insert into full queue");

    // The final result of a transaction returns the block to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_load && !r_link[0].valid) |=>
        (state_reg == ST_IDLE && m_tlast))
        else $error("final result not marked last");

endmodule
`default_nettype wire

@@ rtl/core/rtdq_qcell.sv @@
`default_nettype none
module rtdq_qcell
    import rtdq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic [1:0] op,
    input  wire pkt_t   new_pkt,
    input  wire qlink_t left,
    input  wire qlink_t right,
    output qlink_t      self
);

    logic valid_reg;
    logic valid_next;
    pkt_t pkt_reg;
    pkt_t pkt_next;
    logic le;

    // The new packet goes behind this entry when this entry is not later.
    assign le = valid_reg && (pkt_reg.release_time <= new_pkt.release_time);

    assign self.valid = valid_reg;
    assign self.le    = le;
    assign self.pkt   = pkt_reg;

    // Next contents of the cell.
    always_comb
    begin
        valid_next = valid_reg;
        pkt_next   = pkt_reg;
        case (op)
            Q_HOLD:
            begin
                valid_next = valid_reg;
            end
            Q_SHIFT:
            begin
                valid_next = right.valid;
                pkt_next   = right.pkt;
            end
            Q_INSERT:
            begin
                if (le)
                begin
                    valid_next = valid_reg;
                end
                else if (left.le)
                begin
                    valid_next = 1'b1;
                    pkt_next   = new_pkt;
                end
                else
                begin
                    valid_next = left.valid;
                    pkt_next   = left.pkt;
                end
            end
            Q_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/rtdq_rcell.sv @@
`default_nettype none
module rtdq_rcell
    import rtdq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic [1:0] op,
    input  wire pkt_t   new_pkt,
    input  wire rlink_t left,
    input  wire rlink_t right,
    output rlink_t      self
);

    logic valid_reg;
    logic valid_next;
    pkt_t pkt_reg;
    pkt_t pkt_next;

    assign self.valid = valid_reg;
    assign self.pkt   = pkt_reg;

    // The first empty cell takes a pushed packet; a pop moves all towards the head.
    always_comb
    begin
        valid_next = valid_reg;
        pkt_next   = pkt_reg;
        case (op)
            R_PUSH:
            begin
                if (!valid_reg && left.valid)
                begin
                    valid_next = 1'b1;
                    pkt_next   = new_pkt;
                end
            end
            R_POP:
            begin
                valid_next = right.valid;
                pkt_next   = right.pkt;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
    end

endmodule
`default_nettype wire

@@ tb/release_time_delay_queue_checker.sv @@
`timescale 1ns / 1ps
module release_time_delay_queue_checker
    import rtdq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [20:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [199:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [287:0] m_tdata,
    input  wire logic [2:0]   m_tuser,
    input  wire logic         m_tlast,
    output int                pending,
    output int                errors,
    output int                results_seen
);

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [2:0]  kind;
        logic        stored;
        pkt_t        pkt;
        logic        nonempty;
        logic [63:0] next_time;
        logic [20:0] queued;
        logic        last;
    } outcome_t;

    // Shadow copy of the descriptor table and the byte budget.
    logic        slot_valid [SLOTS];
    pkt_t        slot_pkt   [SLOTS];
    logic [63:0] slot_order [SLOTS];
    logic [63:0] arrivals;
    logic [20:0] byte_sum;
    logic [20:0] budget;
    outcome_t    outcomes [$];

    function automatic int head_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_valid[i])
            begin
                if (best < 0 || slot_pkt[i].release_time < slot_pkt[best].release_time ||
                    (slot_pkt[i].release_time == slot_pkt[best].release_time &&
                     slot_order[i] < slot_order[best]))
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < SLOTS; i++)
            if (!slot_valid[i])
                return i;
        return -1;
    endfunction

    function automatic outcome_t blank(logic [2:0] kind, logic stored);
        outcome_t o;
        o = '0;
        o.kind = kind;
        o.stored = stored;
        return o;
    endfunction

    // Removes a slot and returns it as an evicted or released packet.
    function automatic outcome_t take_slot(int i, logic [2:0] kind);
        outcome_t o;
        o = blank(kind, 1'b0);
        o.pkt = slot_pkt[i];
        slot_valid[i] = 1'b0;
        if (byte_sum >= slot_pkt[i].length)
            byte_sum = byte_sum - slot_pkt[i].length;
        else
            byte_sum = '0;
        return o;
    endfunction

    // Works out every result that one transaction on the input causes.
    task automatic forecast(logic [1:0] mode, logic [199:0] d);
        outcome_t    step [$];
        pkt_t        p;
        int          h;
        int          f;
        p.release_time    = d[63:0];
        p.handle          = d[79:64];
        p.length          = d[95:80];
        p.seq             = d[159:96];
        p.profile_version = d[191:160];
        p.direction       = d[199:192];
        if (mode == MODE_PUSH)
        begin
            h = head_slot();
            while (int'(byte_sum) + int'(p.length) > int'(budget) && h >= 0 &&
                   step.size() < SLOTS)
            begin
                step.push_back(take_slot(h, K_EVICT));
                h = head_slot();
            end
            if (p.length > budget)
                step.push_back(blank(K_PUSH, 1'b0));
            else
            begin
                f = free_slot();
                if (f < 0)
                begin
                    h = head_slot();
                    if (h >= 0 && step.size() < SLOTS)
                        step.push_back(take_slot(h, K_EVICT));
                    f = free_slot();
                end
                if (f >= 0)
                begin
                    slot_valid[f] = 1'b1;
                    slot_pkt[f] = p;
                    slot_order[f] = arrivals;
                    arrivals = arrivals + 1;
                    byte_sum = byte_sum + p.length;
                end
                step.push_back(blank(K_PUSH, f >= 0));
            end
        end
        else if (mode == MODE_POP)
        begin
            h = head_slot();
            if (h >= 0 && slot_pkt[h].release_time <= p.release_time)
                step.push_back(take_slot(h, K_RELEASE));
            else
                step.push_back(blank(K_NONE, 1'b0));
        end
        else if (mode == MODE_CLEAR)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_valid[i] = 1'b0;
            byte_sum = '0;
            step.push_back(blank(K_CLEAR, 1'b0));
        end
        else
            step.push_back(blank(K_NONE, 1'b0));

        // Every result carries the queue status after the whole transaction.
        h = head_slot();
        for (int k = 0; k < step.size(); k++)
        begin
            step[k].nonempty = (h >= 0);
            step[k].next_time = (h >= 0) ? slot_pkt[h].release_time : 64'd0;
            step[k].queued = byte_sum;
            step[k].last = (k == step.size() - 1);
            outcomes.push_back(step[k]);
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // Compares one output transaction with the oldest expectation.
    task automatic compare(outcome_t w);
        if (m_tuser != w.kind)
            report("kind", m_tuser, w.kind);
        if (m_tdata[0] != w.stored)
            report("accepted", m_tdata[0], w.stored);
        if (m_tdata[64:1] != w.pkt.release_time)
            report("pkt_release_time", m_tdata[64:1], w.pkt.release_time);
        if (m_tdata[128:65] != w.pkt.seq)
            report("pkt_seq", m_tdata[128:65], w.pkt.seq);
        if (m_tdata[160:129] != w.pkt.profile_version)
            report("pkt_profile_version", m_tdata[160:129], w.pkt.profile_version);
        if (m_tdata[168:161] != w.pkt.direction)
            report("pkt_direction", m_tdata[168:161], w.pkt.direction);
        if (m_tdata[184:169] != w.pkt.handle)
            report("pkt_handle", m_tdata[184:169], w.pkt.handle);
        if (m_tdata[200:185] != w.pkt.length)
            report("pkt_length", m_tdata[200:185], w.pkt.length);
        if (m_tdata[201] != w.nonempty)
            report("queue_nonempty", m_tdata[201], w.nonempty);
        if (m_tdata[265:202] != w.next_time)
            report("next_release_time", m_tdata[265:202], w.next_time);
        if (m_tdata[286:266] != w.queued)
            report("queued_bytes", m_tdata[286:266], w.queued);
        if (m_tdata[287] != 1'b0)
            report("padding bit", m_tdata[287], 1'b0);
        if (m_tlast != w.last)
            report("last", m_tlast, w.last);
    endtask

    // Tracks configuration writes and both channels.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_valid[i] = 1'b0;
            arrivals = '0;
            byte_sum = '0;
            budget = BUDGET_RESET;
            outcomes.delete();
            errors = 0;
            results_seen = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                budget = cfg_wdata;
            if (s_tvalid && s_tready)
                forecast(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (outcomes.size() == 0)
                    report("unexpected result, kind", m_tuser, 0);
                else
                    compare(outcomes.pop_front());
            end
            pending = outcomes.size();
        end
    end

endmodule

@@ tb/release_time_delay_queue_tb.sv @@
`timescale 1ns / 1ps
module release_time_delay_queue_tb
    import rtdq_pkg::*;
();

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE = 60;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [20:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [287:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    int           pending;
    int           errors;
    int           results_seen;
    int           send_gap_pct;
    int           recv_gap_pct;
    int           stall_cycles = 0;
    int           items_sent;
    int           budgets_used;

    release_time_delay_queue u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    release_time_delay_queue_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .pending(pending), .errors(errors), .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random according to the current idling mix.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_gap_pct);

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without a transaction", stall_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send(logic [1:0] mode, logic [63:0] ts, logic [15:0] handle,
                        logic [15:0] len, logic [63:0] seq, logic [31:0] pver,
                        logic [7:0] dir);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct && gap < 8)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {dir, pver, seq, len, handle, ts};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic push_item(logic [63:0] ts, logic [15:0] len);
        send(MODE_PUSH, ts, 16'($urandom), len, {$urandom, $urandom}, $urandom,
             8'($urandom));
    endtask

    // Random transaction, mostly pushes and pops around a narrow time window.
    task automatic random_item(int len_cap);
        int          pick;
        logic [63:0] ts;
        logic [15:0] len;
        pick = $urandom_range(99);
        ts = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(400));
        len = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(len_cap));
        if (pick < 58)
            push_item(ts, len);
        else if (pick < 88)
            send(MODE_POP, ts, 16'($urandom), 16'($urandom), {$urandom, $urandom},
                 $urandom, 8'($urandom));
        else if (pick < 94)
            send(MODE_CLEAR, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
                 {$urandom, $urandom}, $urandom, 8'($urandom));
        else
            send(MODE_UNUSED, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
                 {$urandom, $urandom}, $urandom, 8'($urandom));
    endtask

    // Lets every expected result arrive and the block settle before a write.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_budget(logic [20:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        budgets_used++;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = MODE_PUSH;
        items_sent   = 0;
        budgets_used = 1;
        send_gap_pct = 36;
        recv_gap_pct = 67;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, unused mode, field extremes, ties and a full table.
        send(MODE_POP, '1, '1, '1, '1, '1, '1);
        send(MODE_UNUSED, '1, '1, '1, '1, '1, '1);
        send(MODE_CLEAR, '0, '0, '0, '0, '0, '0);
        send(MODE_PUSH, '1, '1, '1, '1, '1, '1);
        send(MODE_PUSH, '0, '0, '0, '0, '0, '0);
        send(MODE_PUSH, 64'd100, 16'h1234, 16'd100, 64'd1, 32'd1, 8'd1);
        send(MODE_PUSH, 64'd100, 16'h4321, 16'd100, 64'd2, 32'd2, 8'd2);
        send(MODE_POP, 64'd50, '0, '0, '0, '0, '0);
        send(MODE_POP, 64'd99, '0, '0, '0, '0, '0);
        send(MODE_POP, 64'd100, '0, '0, '0, '0, '0);
        for (int i = 0; i < 15; i++)
            push_item(64'(200 + $urandom_range(5)), 16'd1000);
        send(MODE_CLEAR, '1, '1, '1, '1, '1, '1);

        // Random phases, each under its own byte budget, with three idling mixes.
        repeat (60) random_item(4000);
        set_budget(21'd2500);
        repeat (60) random_item(1200);
        send_gap_pct = 67;
        recv_gap_pct = 36;
        set_budget(21'd0);
        repeat (40) random_item(0);
        set_budget(21'd1048576);
        repeat (60) random_item(65535);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        set_budget(21'd1);
        repeat (40) random_item(2);
        drain();

        $display("Sent %0d transactions under %0d byte budgets; checked %0d results.",
                 items_sent, budgets_used, results_seen);
        $display("Covered evictions, releases, rejections, clears and idle mixes.");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
